@@ src/iosh_pkg.sv @@
// ----------------------------------------------------------------------------
// iosh_pkg: shared definitions for the I/O statistics histogram
// Bin memory layout, command codes and the latency and segment binning
// functions.
// ----------------------------------------------------------------------------
package iosh_pkg;

    localparam int LAT_BINS = 16;
    localparam int SG_BINS  = 8;

    localparam int LAT_W = $clog2(LAT_BINS);
    localparam int SG_W  = $clog2(SG_BINS);

    // One memory holds all bins: read latency, write latency, segment count.
    localparam int LAT_RD_BASE = 0;
    localparam int LAT_WR_BASE = LAT_BINS;
    localparam int SG_BASE     = 2 * LAT_BINS;
    localparam int BIN_DEPTH   = 2 * LAT_BINS + SG_BINS;
    localparam int BIN_ADDR_W  = $clog2(BIN_DEPTH);
    localparam int CNT_W       = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LAT_LOG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SG_LINEAR_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SG_LOG_OFFSET  = 2'd2;

    localparam logic [2:0] CMD_ISSUE    = 3'd0;
    localparam logic [2:0] CMD_LATENCY  = 3'd1;
    localparam logic [2:0] CMD_INF_DEC  = 3'd2;
    localparam logic [2:0] CMD_FAILOVER = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    localparam logic [1:0] GRP_LAT_RD = 2'd0;
    localparam logic [1:0] GRP_LAT_WR = 2'd1;
    localparam logic [1:0] GRP_SG     = 2'd2;
    localparam logic [1:0] GRP_SCALAR = 2'd3;

    localparam logic [4:0] SC_REQ_RD     = 5'd0;
    localparam logic [4:0] SC_BYTE_RD    = 5'd1;
    localparam logic [4:0] SC_REQ_WR     = 5'd2;
    localparam logic [4:0] SC_BYTE_WR    = 5'd3;
    localparam logic [4:0] SC_INFLIGHT   = 5'd4;
    localparam logic [4:0] SC_FAILOVER   = 5'd5;
    localparam logic [4:0] SC_LAT_RD_MAX = 5'd6;
    localparam logic [4:0] SC_LAT_WR_MAX = 5'd7;
    localparam logic [4:0] SC_SG_TOTAL   = 5'd8;
    localparam int         SCALAR_CNT    = 9;

    function automatic logic [4:0] flog2_32(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 1; i < 32; i++) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] flog2_16(input logic [15:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = 1; i < 16; i++) begin
            if (v[i]) begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [LAT_W-1:0] lat_bin(input logic [31:0] ms,
                                                 input logic [4:0]  off);
        logic signed [7:0] id;
        id = $signed({3'b000, flog2_32(ms)}) + 8'sd1 - $signed({3'b000, off});
        if (ms == 32'd0 || id < 0) begin
            id = 8'sd0;
        end else if (id > LAT_BINS - 1) begin
            id = 8'(LAT_BINS - 1);
        end
        return LAT_W'(id);
    endfunction

    function automatic logic [SG_W-1:0] sg_bin(input logic [15:0] cnt,
                                               input logic [2:0]  lin,
                                               input logic [3:0]  off);
        logic signed [7:0] id;
        logic signed [7:0] floor_id;
        floor_id = $signed({5'b00000, lin}) + 8'sd1;
        if (cnt <= {13'd0, lin}) begin
            id = $signed({5'b00000, cnt[2:0]});
        end else begin
            id = $signed({4'b0000, flog2_16(cnt)}) + $signed({5'b00000, lin})
                 + 8'sd1 - $signed({4'b0000, off});
            if (id < floor_id) begin
                id = floor_id;
            end
        end
        if (id > SG_BINS - 1) begin
            id = 8'(SG_BINS - 1);
        end
        return SG_W'(id);
    endfunction

endpackage

@@ src/iosh_ram.sv @@
// ----------------------------------------------------------------------------
// iosh_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module iosh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/io_stats_log_histogram.sv @@
// ----------------------------------------------------------------------------
// io_stats_log_histogram: I/O statistics counter bank
// Every request first has its bin read from the bin memory, whose read data
// is registered; in the execute state, issue and latency requests increment
// the bin and write it back, the scalar counters are updated and the result
// register is loaded. A new request is taken only after the read-modify-write
// of the previous one has finished, so no forwarding is needed. The input is
// also held off while a result waits in the result register and the receiver
// is not ready.
// Clears take effect at once through per-bin valid bits, with no sweep after
// reset or after a clear request.
// ----------------------------------------------------------------------------
module io_stats_log_histogram (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [iosh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [iosh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [2:0]                         i_cmd,
    input  logic                               i_is_read,
    input  logic [15:0]                        i_sg_count,
    input  logic [31:0]                        i_header_len,
    input  logic [31:0]                        i_payload_len,
    input  logic [31:0]                        i_latency_ms,
    input  logic [1:0]                         i_read_group,
    input  logic [4:0]                         i_read_index,
    input  logic [3:0]                         i_clear_mask,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [63:0]                        o_value,
    output logic                               o_status
);

    localparam int AW = iosh_pkg::BIN_ADDR_W;
    localparam int DW = iosh_pkg::CNT_W;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0]    r_state;
    logic [4:0]    r_lat_off;
    logic [2:0]    r_sg_lin;
    logic [3:0]    r_sg_off;

    logic [2:0]    r_cmd;
    logic          r_dir;
    logic [31:0]   r_len;
    logic [31:0]   r_ms;
    logic [1:0]    r_grp;
    logic [4:0]    r_idx;
    logic [3:0]    r_mask;
    logic [AW-1:0] r_addr;
    logic          r_bad;
    logic          r_rd_vld;

    logic [iosh_pkg::BIN_DEPTH-1:0] r_bin_vld;
    logic [iosh_pkg::BIN_DEPTH-1:0] n_bin_vld;

    logic [63:0]   r_req_rd, r_req_wr, r_byte_rd, r_byte_wr;
    logic [63:0]   r_failover, r_sg_total;
    logic [31:0]   r_inflight, r_lat_rd_max, r_lat_wr_max;

    logic          r_out_valid;
    logic [63:0]   r_out_value;
    logic          r_out_status;

    logic          w_in_acc;
    logic          w_exec;
    logic [AW-1:0] w_addr;
    logic          w_bad;
    logic          w_ram_we;
    logic [DW-1:0] w_ram_rdata;
    logic [DW-1:0] w_bin;
    logic [63:0]   w_scalar;
    logic          w_scalar_bad;

    assign o_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign w_in_acc = i_valid && o_ready;
    assign w_exec   = (r_state == ST_EXEC);

    // Bad read index check and bin address, both from the incoming request.
    always_comb begin
        w_bad  = 1'b0;
        w_addr = '0;
        case (i_cmd)
            iosh_pkg::CMD_ISSUE: begin
                w_addr = AW'(iosh_pkg::SG_BASE)
                         + AW'(iosh_pkg::sg_bin(i_sg_count, r_sg_lin, r_sg_off));
            end
            iosh_pkg::CMD_LATENCY: begin
                w_addr = AW'(i_is_read ? iosh_pkg::LAT_RD_BASE : iosh_pkg::LAT_WR_BASE)
                         + AW'(iosh_pkg::lat_bin(i_latency_ms, r_lat_off));
            end
            iosh_pkg::CMD_READ: begin
                case (i_read_group)
                    iosh_pkg::GRP_LAT_RD: begin
                        w_bad  = 32'(i_read_index) >= iosh_pkg::LAT_BINS;
                        w_addr = AW'(iosh_pkg::LAT_RD_BASE) + AW'(i_read_index);
                    end
                    iosh_pkg::GRP_LAT_WR: begin
                        w_bad  = 32'(i_read_index) >= iosh_pkg::LAT_BINS;
                        w_addr = AW'(iosh_pkg::LAT_WR_BASE) + AW'(i_read_index);
                    end
                    iosh_pkg::GRP_SG: begin
                        w_bad  = 32'(i_read_index) >= iosh_pkg::SG_BINS;
                        w_addr = AW'(iosh_pkg::SG_BASE) + AW'(i_read_index);
                    end
                    default: begin
                        w_bad = 32'(i_read_index) >= iosh_pkg::SCALAR_CNT;
                    end
                endcase
                if (w_bad) begin
                    w_addr = '0;
                end
            end
            default: begin
                w_addr = '0;
            end
        endcase
    end

    iosh_ram #(
        .WIDTH (DW),
        .DEPTH (iosh_pkg::BIN_DEPTH)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata (w_bin + 64'd1),
        .i_raddr (w_addr),
        .o_rdata (w_ram_rdata)
    );

    // A bin that was cleared or never written reads as zero.
    assign w_bin    = r_rd_vld ? w_ram_rdata : '0;
    assign w_ram_we = w_exec && (r_cmd == iosh_pkg::CMD_ISSUE || r_cmd == iosh_pkg::CMD_LATENCY);

    always_comb begin
        n_bin_vld = r_bin_vld;
        if (w_exec && r_cmd == iosh_pkg::CMD_CLEAR) begin
            for (int i = 0; i < iosh_pkg::BIN_DEPTH; i++) begin
                if (r_mask[1] && i < iosh_pkg::SG_BASE) begin
                    n_bin_vld[i] = 1'b0;
                end
                if (r_mask[2] && i >= iosh_pkg::SG_BASE) begin
                    n_bin_vld[i] = 1'b0;
                end
            end
        end
        if (w_ram_we) begin
            n_bin_vld[r_addr] = 1'b1;
        end
    end

    always_comb begin
        w_scalar     = '0;
        w_scalar_bad = 1'b0;
        case (r_idx)
            iosh_pkg::SC_REQ_RD:     w_scalar = r_req_rd;
            iosh_pkg::SC_BYTE_RD:    w_scalar = r_byte_rd;
            iosh_pkg::SC_REQ_WR:     w_scalar = r_req_wr;
            iosh_pkg::SC_BYTE_WR:    w_scalar = r_byte_wr;
            iosh_pkg::SC_INFLIGHT:   w_scalar = {32'd0, r_inflight};
            iosh_pkg::SC_FAILOVER:   w_scalar = r_failover;
            iosh_pkg::SC_LAT_RD_MAX: w_scalar = {32'd0, r_lat_rd_max};
            iosh_pkg::SC_LAT_WR_MAX: w_scalar = {32'd0, r_lat_wr_max};
            iosh_pkg::SC_SG_TOTAL:   w_scalar = r_sg_total;
            default:                 w_scalar_bad = 1'b1;
        endcase
    end

    // Request capture and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_lat_off <= 5'd0;
            r_sg_lin  <= 3'd4;
            r_sg_off  <= 4'd2;
            r_bin_vld <= '0;
        end else begin
            r_bin_vld <= n_bin_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iosh_pkg::CFG_LAT_LOG_OFFSET: r_lat_off <= i_cfg_data[4:0];
                    iosh_pkg::CFG_SG_LINEAR_MAX:  r_sg_lin  <= i_cfg_data[2:0];
                    iosh_pkg::CFG_SG_LOG_OFFSET:  r_sg_off  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_state <= ST_EXEC;
            end else if (w_exec) begin
                r_state <= ST_IDLE;
            end
        end
        if (w_in_acc) begin
            r_cmd    <= i_cmd;
            r_dir    <= i_is_read;
            r_len    <= i_header_len + i_payload_len;
            r_ms     <= i_latency_ms;
            r_grp    <= i_read_group;
            r_idx    <= i_read_index;
            r_mask   <= i_clear_mask;
            r_addr   <= w_addr;
            r_bad    <= w_bad;
            r_rd_vld <= n_bin_vld[w_addr];
        end
    end

    // Counter updates and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_rd     <= '0;
            r_req_wr     <= '0;
            r_byte_rd    <= '0;
            r_byte_wr    <= '0;
            r_failover   <= '0;
            r_sg_total   <= '0;
            r_inflight   <= '0;
            r_lat_rd_max <= '0;
            r_lat_wr_max <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid  <= 1'b1;
                r_out_value  <= '0;
                r_out_status <= 1'b0;
                case (r_cmd)
                    iosh_pkg::CMD_ISSUE: begin
                        r_sg_total <= r_sg_total + 64'd1;
                        r_inflight <= r_inflight + 32'd1;
                        if (r_dir) begin
                            r_req_rd  <= r_req_rd + 64'd1;
                            r_byte_rd <= r_byte_rd + {32'd0, r_len};
                        end else begin
                            r_req_wr  <= r_req_wr + 64'd1;
                            r_byte_wr <= r_byte_wr + {32'd0, r_len};
                        end
                    end
                    iosh_pkg::CMD_LATENCY: begin
                        if (r_dir && r_lat_rd_max < r_ms) begin
                            r_lat_rd_max <= r_ms;
                        end
                        if (!r_dir && r_lat_wr_max < r_ms) begin
                            r_lat_wr_max <= r_ms;
                        end
                    end
                    iosh_pkg::CMD_INF_DEC: begin
                        r_inflight <= r_inflight - 32'd1;
                    end
                    iosh_pkg::CMD_FAILOVER: begin
                        r_failover <= r_failover + 64'd1;
                    end
                    iosh_pkg::CMD_READ: begin
                        if (r_grp == iosh_pkg::GRP_SCALAR) begin
                            r_out_value  <= w_scalar_bad ? 64'd0 : w_scalar;
                            r_out_status <= w_scalar_bad;
                        end else begin
                            r_out_value  <= r_bad ? 64'd0 : w_bin;
                            r_out_status <= r_bad;
                        end
                    end
                    iosh_pkg::CMD_CLEAR: begin
                        r_out_status <= (r_mask == 4'd0);
                        if (r_mask[0]) begin
                            r_req_rd   <= '0;
                            r_req_wr   <= '0;
                            r_byte_rd  <= '0;
                            r_byte_wr  <= '0;
                            r_failover <= '0;
                        end
                        if (r_mask[1]) begin
                            r_lat_rd_max <= '0;
                            r_lat_wr_max <= '0;
                        end
                        if (r_mask[2]) begin
                            r_sg_total <= '0;
                        end
                        if (r_mask[3]) begin
                            r_inflight <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // Every accepted request is worked on in the next cycle.
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execution");

    // Execution always produces exactly one result.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (r_out_valid && r_state == ST_IDLE))
        else $error("execution did not load the result register");

    // A bin written back is marked valid afterwards.
    a_bin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |=> r_bin_vld[$past(r_addr)])
        else $error("written bin not marked valid");

    // A read with a bad bin index returns zero with error status.
    a_bad_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_cmd == iosh_pkg::CMD_READ && r_grp != iosh_pkg::GRP_SCALAR && r_bad)
        |=> (r_out_status && r_out_value == 64'd0))
        else $error("bad bin index read not reported");

endmodule

@@ tb/io_stats_log_histogram_tb.sv @@
// ----------------------------------------------------------------------------
// io_stats_log_histogram_tb: self-checking bench for the I/O statistics unit
// Drives issue, latency, in-flight, failover, read and clear requests through
// the valid/ready input and predicts every result with a behavioral copy of
// the counter bank. Results are checked in order against that prediction.
// Covers corner events, several bin configurations with their extremes, a
// long output stall, and a long random run with idle cycles on both sides.
// ----------------------------------------------------------------------------
module io_stats_log_histogram_tb;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // Bit positions of the clear mask.
    localparam int CLR_REQ  = 0;
    localparam int CLR_LAT  = 1;
    localparam int CLR_SEG  = 2;
    localparam int CLR_INFL = 3;

    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [2:0]  cmd;
        logic        is_read;
        logic [15:0] sg_count;
        logic [31:0] header_len;
        logic [31:0] payload_len;
        logic [31:0] latency_ms;
        logic [1:0]  read_group;
        logic [4:0]  read_index;
        logic [3:0]  clear_mask;
    } t_io_req;

    typedef struct {
        logic [63:0] value;
        logic        status;
    } t_io_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_cmd = '0;
    logic        i_is_read = 1'b0;
    logic [15:0] i_sg_count = '0;
    logic [31:0] i_header_len = '0;
    logic [31:0] i_payload_len = '0;
    logic [31:0] i_latency_ms = '0;
    logic [1:0]  i_read_group = '0;
    logic [4:0]  i_read_index = '0;
    logic [3:0]  i_clear_mask = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_value;
    logic        o_status;

    io_stats_log_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_is_read     (i_is_read),
        .i_sg_count    (i_sg_count),
        .i_header_len  (i_header_len),
        .i_payload_len (i_payload_len),
        .i_latency_ms  (i_latency_ms),
        .i_read_group  (i_read_group),
        .i_read_index  (i_read_index),
        .i_clear_mask  (i_clear_mask),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    // Predicted state of the counter bank and its configuration.
    logic [4:0]  cfg_lat_off = 5'd0;
    logic [2:0]  cfg_sg_lin = 3'd4;
    logic [3:0]  cfg_sg_off = 4'd2;
    logic [63:0] lat_rd_hist [iosh_pkg::LAT_BINS] = '{default: '0};
    logic [63:0] lat_wr_hist [iosh_pkg::LAT_BINS] = '{default: '0};
    logic [63:0] seg_hist [iosh_pkg::SG_BINS] = '{default: '0};
    logic [31:0] lat_rd_peak = '0;
    logic [31:0] lat_wr_peak = '0;
    logic [63:0] seg_total = '0;
    logic [63:0] req_cnt [2] = '{default: '0};
    logic [63:0] byte_sum [2] = '{default: '0};
    logic [31:0] inflight = '0;
    logic [63:0] failovers = '0;

    t_io_resp pending_results [$];
    int       mismatch_cnt = 0;
    bit       quiet = 1'b0;
    int       hold_req = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("io_stats_log_histogram_tb: done, errors");
        $finish;
    end

    function automatic int msb_pos(input logic [31:0] v);
        int pos;
        pos = 0;
        for (int b = 0; b < 32; b++) begin
            if (v[b]) begin
                pos = b;
            end
        end
        return pos;
    endfunction

    function automatic int lat_bucket(input logic [31:0] ms);
        int id;
        if (ms == 32'd0) begin
            return 0;
        end
        id = msb_pos(ms) - int'(cfg_lat_off) + 1;
        if (id < 0) begin
            id = 0;
        end
        if (id > iosh_pkg::LAT_BINS - 1) begin
            id = iosh_pkg::LAT_BINS - 1;
        end
        return id;
    endfunction

    function automatic int seg_bucket(input logic [15:0] cnt);
        int id;
        if (int'(cnt) <= int'(cfg_sg_lin)) begin
            id = int'(cnt);
        end else begin
            id = msb_pos({16'd0, cnt}) + int'(cfg_sg_lin) - int'(cfg_sg_off) + 1;
            if (id < int'(cfg_sg_lin) + 1) begin
                id = int'(cfg_sg_lin) + 1;
            end
        end
        if (id > iosh_pkg::SG_BINS - 1) begin
            id = iosh_pkg::SG_BINS - 1;
        end
        return id;
    endfunction

    // Updates the predicted counters for one request and returns its result.
    function automatic t_io_resp apply_event(input t_io_req r);
        t_io_resp res;
        int       b;
        res.value = '0;
        res.status = 1'b0;
        case (r.cmd)
            iosh_pkg::CMD_ISSUE: begin
                seg_hist[seg_bucket(r.sg_count)] += 64'd1;
                seg_total += 64'd1;
                req_cnt[r.is_read] += 64'd1;
                // The two lengths add in 32 bits before reaching the total.
                byte_sum[r.is_read] += {32'd0, 32'(r.header_len + r.payload_len)};
                inflight += 32'd1;
            end
            iosh_pkg::CMD_LATENCY: begin
                b = lat_bucket(r.latency_ms);
                if (r.is_read) begin
                    lat_rd_hist[b] += 64'd1;
                    if (lat_rd_peak < r.latency_ms) begin
                        lat_rd_peak = r.latency_ms;
                    end
                end else begin
                    lat_wr_hist[b] += 64'd1;
                    if (lat_wr_peak < r.latency_ms) begin
                        lat_wr_peak = r.latency_ms;
                    end
                end
            end
            iosh_pkg::CMD_INF_DEC: begin
                inflight -= 32'd1;
            end
            iosh_pkg::CMD_FAILOVER: begin
                failovers += 64'd1;
            end
            iosh_pkg::CMD_READ: begin
                case (r.read_group)
                    iosh_pkg::GRP_LAT_RD: begin
                        if (r.read_index < iosh_pkg::LAT_BINS) begin
                            res.value = lat_rd_hist[r.read_index];
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                    iosh_pkg::GRP_LAT_WR: begin
                        if (r.read_index < iosh_pkg::LAT_BINS) begin
                            res.value = lat_wr_hist[r.read_index];
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                    iosh_pkg::GRP_SG: begin
                        if (r.read_index < iosh_pkg::SG_BINS) begin
                            res.value = seg_hist[r.read_index];
                        end else begin
                            res.status = 1'b1;
                        end
                    end
                    default: begin
                        case (r.read_index)
                            iosh_pkg::SC_REQ_RD:     res.value = req_cnt[1];
                            iosh_pkg::SC_BYTE_RD:    res.value = byte_sum[1];
                            iosh_pkg::SC_REQ_WR:     res.value = req_cnt[0];
                            iosh_pkg::SC_BYTE_WR:    res.value = byte_sum[0];
                            iosh_pkg::SC_INFLIGHT:   res.value = {32'd0, inflight};
                            iosh_pkg::SC_FAILOVER:   res.value = failovers;
                            iosh_pkg::SC_LAT_RD_MAX: res.value = {32'd0, lat_rd_peak};
                            iosh_pkg::SC_LAT_WR_MAX: res.value = {32'd0, lat_wr_peak};
                            iosh_pkg::SC_SG_TOTAL:   res.value = seg_total;
                            default:                 res.status = 1'b1;
                        endcase
                    end
                endcase
            end
            iosh_pkg::CMD_CLEAR: begin
                if (r.clear_mask == 4'd0) begin
                    res.status = 1'b1;
                end
                if (r.clear_mask[CLR_REQ]) begin
                    req_cnt = '{default: '0};
                    byte_sum = '{default: '0};
                    failovers = '0;
                end
                if (r.clear_mask[CLR_LAT]) begin
                    lat_rd_hist = '{default: '0};
                    lat_wr_hist = '{default: '0};
                    lat_rd_peak = '0;
                    lat_wr_peak = '0;
                end
                if (r.clear_mask[CLR_SEG]) begin
                    seg_hist = '{default: '0};
                    seg_total = '0;
                end
                if (r.clear_mask[CLR_INFL]) begin
                    inflight = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Result checker: every accepted result is compared with the oldest
    // prediction.
    initial begin
        t_io_resp want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: value=%h status=%0d",
                                              o_value, o_status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_value !== want.value) begin
                        report_mismatch($sformatf("value %h, predicted %h",
                                                  o_value, want.value));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  o_status, want.status));
                    end
                end
            end
        end
    end

    // Result side ready: random short stalls, plus long hold-offs on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(99) < 3) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offers one request and waits for it to be accepted. Valid stays high
    // afterwards unless a random gap is taken.
    task automatic send_req(input t_io_req r);
        if (!i_valid) begin
            i_valid <= 1'b1;
        end
        i_cmd         <= r.cmd;
        i_is_read     <= r.is_read;
        i_sg_count    <= r.sg_count;
        i_header_len  <= r.header_len;
        i_payload_len <= r.payload_len;
        i_latency_ms  <= r.latency_ms;
        i_read_group  <= r.read_group;
        i_read_index  <= r.read_index;
        i_clear_mask  <= r.clear_mask;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_results.push_back(apply_event(r));
        if (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stops offering requests and waits until every result is back and the
    // pipeline has settled.
    task automatic drain_block();
        if (i_valid) begin
            i_valid <= 1'b0;
        end
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive cycles; unused upper data
    // bits carry noise.
    task automatic set_config(input logic [4:0] lat_off, input logic [2:0] lin,
                              input logic [3:0] seg_off);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= iosh_pkg::CFG_LAT_LOG_OFFSET;
        i_cfg_data <= lat_off;
        @(posedge i_clk);
        i_cfg_idx  <= iosh_pkg::CFG_SG_LINEAR_MAX;
        i_cfg_data <= {2'($urandom), lin};
        @(posedge i_clk);
        i_cfg_idx  <= iosh_pkg::CFG_SG_LOG_OFFSET;
        i_cfg_data <= {1'($urandom), seg_off};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_lat_off = lat_off;
        cfg_sg_lin  = lin;
        cfg_sg_off  = seg_off;
    endtask

    function automatic t_io_req noise_req(input logic [2:0] cmd);
        t_io_req r;
        r.cmd         = cmd;
        r.is_read     = 1'($urandom);
        r.sg_count    = 16'($urandom);
        r.header_len  = $urandom;
        r.payload_len = $urandom;
        r.latency_ms  = $urandom;
        r.read_group  = 2'($urandom);
        r.read_index  = 5'($urandom);
        r.clear_mask  = 4'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] rand_seg_count();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom_range(0, 20));
            5:             return 16'h1 << $urandom_range(0, 15);
            6:             return 16'hFFFF;
            default:       return 16'($urandom) >> $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [31:0] rand_latency();
        if ($urandom_range(0, 9) == 0) begin
            return 32'd0;
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic t_io_req rand_event();
        t_io_req r;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 28) begin
            r = noise_req(iosh_pkg::CMD_ISSUE);
        end else if (pick < 56) begin
            r = noise_req(iosh_pkg::CMD_LATENCY);
        end else if (pick < 62) begin
            r = noise_req(iosh_pkg::CMD_INF_DEC);
        end else if (pick < 66) begin
            r = noise_req(iosh_pkg::CMD_FAILOVER);
        end else if (pick < 92) begin
            r = noise_req(iosh_pkg::CMD_READ);
        end else if (pick < 96) begin
            r = noise_req(iosh_pkg::CMD_CLEAR);
        end else begin
            r = noise_req($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7);
        end
        r.sg_count = rand_seg_count();
        r.latency_ms = rand_latency();
        // Mostly valid indexes for the chosen group; the rest spans all 32.
        if ($urandom_range(0, 9) != 0) begin
            case (r.read_group)
                iosh_pkg::GRP_LAT_RD, iosh_pkg::GRP_LAT_WR:
                    r.read_index = 5'($urandom_range(0, iosh_pkg::LAT_BINS - 1));
                iosh_pkg::GRP_SG:
                    r.read_index = 5'($urandom_range(0, iosh_pkg::SG_BINS - 1));
                default:
                    r.read_index = 5'($urandom_range(0, iosh_pkg::SCALAR_CNT - 1));
            endcase
        end
        return r;
    endfunction

    task automatic send_issue(input logic dir, input logic [15:0] sg,
                              input logic [31:0] hlen, input logic [31:0] plen);
        t_io_req r;
        r = noise_req(iosh_pkg::CMD_ISSUE);
        r.is_read     = dir;
        r.sg_count    = sg;
        r.header_len  = hlen;
        r.payload_len = plen;
        send_req(r);
    endtask

    task automatic send_latency(input logic dir, input logic [31:0] ms);
        t_io_req r;
        r = noise_req(iosh_pkg::CMD_LATENCY);
        r.is_read    = dir;
        r.latency_ms = ms;
        send_req(r);
    endtask

    task automatic send_read(input logic [1:0] grp, input logic [4:0] idx);
        t_io_req r;
        r = noise_req(iosh_pkg::CMD_READ);
        r.read_group = grp;
        r.read_index = idx;
        send_req(r);
    endtask

    task automatic send_clear(input logic [3:0] mask);
        t_io_req r;
        r = noise_req(iosh_pkg::CMD_CLEAR);
        r.clear_mask = mask;
        send_req(r);
    endtask

    // Field extremes, wrap cases, bad indexes, empty clear and spare codes,
    // all under the reset configuration.
    task automatic test_corner_events();
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_INFLIGHT);
        send_issue(1'b1, 16'd0, 32'hFFFF_FFFF, 32'd2);
        send_issue(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_issue(1'b1, 16'd5, 32'd0, 32'd0);
        send_latency(1'b1, 32'd0);
        send_latency(1'b0, 32'hFFFF_FFFF);
        send_latency(1'b1, 32'd1);
        // Three issues outstanding; the fourth decrement wraps below zero.
        repeat (4) send_req(noise_req(iosh_pkg::CMD_INF_DEC));
        send_req(noise_req(iosh_pkg::CMD_FAILOVER));
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_INFLIGHT);
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_BYTE_RD);
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_LAT_WR_MAX);
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_FAILOVER);
        send_read(iosh_pkg::GRP_SG, 5'd7);
        send_read(iosh_pkg::GRP_LAT_WR, 5'd15);
        send_read(iosh_pkg::GRP_LAT_RD, 5'd16);
        send_read(iosh_pkg::GRP_LAT_WR, 5'd31);
        send_read(iosh_pkg::GRP_SG, 5'd8);
        send_read(iosh_pkg::GRP_SCALAR, 5'd9);
        send_clear(4'd0);
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_SG_TOTAL);
        send_clear(4'hF);
        send_req(noise_req(CMD_SPARE6));
        send_req(noise_req(CMD_SPARE7));
        send_read(iosh_pkg::GRP_SCALAR, iosh_pkg::SC_REQ_RD);
        drain_block();
    endtask

    // Bins events under several register settings, extremes included, and
    // reads back every segment bin and eight latency bins after each batch.
    task automatic test_bin_configs();
        logic [4:0] lat_offs [6] = '{5'd0, 5'd31, 5'd31, 5'd0, 5'd3, 5'd0};
        logic [2:0] lins [6]     = '{3'd0, 3'd7, 3'd0, 3'd7, 3'd2, 3'd5};
        logic [3:0] seg_offs [6] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd5, 4'd9};
        for (int s = 0; s < 6; s++) begin
            if (s == 5) begin
                set_config(5'($urandom), 3'($urandom), 4'($urandom));
            end else begin
                set_config(lat_offs[s], lins[s], seg_offs[s]);
            end
            send_clear(4'hF);
            repeat (36) begin
                if ($urandom_range(0, 1)) begin
                    send_issue(1'($urandom), rand_seg_count(), $urandom, $urandom);
                end else begin
                    send_latency(1'($urandom), rand_latency());
                end
            end
            for (int b = 0; b < iosh_pkg::SG_BINS; b++) begin
                send_read(iosh_pkg::GRP_SG, 5'(b));
            end
            for (int b = 0; b < iosh_pkg::LAT_BINS; b += 2) begin
                send_read(b[1] ? iosh_pkg::GRP_LAT_WR : iosh_pkg::GRP_LAT_RD,
                          5'(b + $urandom_range(0, 1)));
            end
            drain_block();
        end
    endtask

    // The result side holds off for a long stretch while requests keep
    // coming, so the unit backs up and stalls its input.
    task automatic test_output_stall();
        hold_req = 150;
        repeat (40) send_req(rand_event());
        drain_block();
    endtask

    // Random traffic in phases with a fresh configuration each; the first
    // phase runs with no idle cycles on either side.
    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            quiet = (p == 0);
            set_config(5'($urandom_range(0, 8)), 3'($urandom), 4'($urandom));
            repeat (290) send_req(rand_event());
            drain_block();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_events();
        test_bin_configs();
        test_output_stall();
        test_random_traffic();
        if (mismatch_cnt == 0) begin
            $display("io_stats_log_histogram_tb: done, clean");
        end else begin
            $display("io_stats_log_histogram_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ io_stats_log_histogram.f @@
src/iosh_pkg.sv
src/iosh_ram.sv
src/io_stats_log_histogram.sv
tb/io_stats_log_histogram_tb.sv
